[rtl/one_wire_audio_command_sender_defines.svh]
// Assertion macros used by the checker file of the command sender.
`ifndef ONE_WIRE_AUDIO_COMMAND_SENDER_DEFINES_SVH
`define ONE_WIRE_AUDIO_COMMAND_SENDER_DEFINES_SVH

// Check that post holds in the same cycle as pre.
`define OWACS_ASSERT_SAME(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("sender check failed");

// Check that post holds in the cycle after pre.
`define OWACS_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("sender check failed");

`endif

[rtl/owacs_pkg.sv]
// Types, codes and byte tables of the one-wire audio command sender.
`default_nettype none
package owacs_pkg;

	typedef enum logic [2:0] {
		OP_TICK       = 3'd0,
		OP_PLAY_TRACK = 3'd1,
		OP_STOP       = 3'd2,
		OP_VOLUME     = 3'd3,
		OP_LOOP       = 3'd4,
		OP_PLAY       = 3'd5,
		OP_PAUSE      = 3'd6,
		OP_NEXT       = 3'd7
	} cmd_t;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_START = 3'd1,
		PH_LEAD  = 3'd2,
		PH_MARK  = 3'd3,
		PH_SPACE = 3'd4,
		PH_END   = 3'd5,
		PH_GAP   = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		PS_IDLE    = 2'd0,
		PS_PLAYING = 2'd1,
		PS_PAUSED  = 2'd2,
		PS_SENDING = 2'd3
	} play_t;

	localparam logic [7:0] CODE_CLEAR     = 8'h0A;
	localparam logic [7:0] CODE_PLAY_SPEC = 8'h0B;
	localparam logic [7:0] CODE_VOLUME    = 8'h0C;
	localparam logic [7:0] CODE_LOOP      = 8'h0E;
	localparam logic [7:0] CODE_PLAY      = 8'h11;
	localparam logic [7:0] CODE_PAUSE     = 8'h12;
	localparam logic [7:0] CODE_STOP      = 8'h13;
	localparam logic [7:0] CODE_NEXT      = 8'h15;

	localparam logic [13:0] VOLUME_MAX  = 14'd30;
	localparam logic [7:0]  START_TICKS = 8'd5;
	localparam logic [7:0]  LEAD_TICKS  = 8'd20;
	localparam logic [7:0]  LONG_TICKS  = 8'd3;
	localparam logic [7:0]  SHORT_TICKS = 8'd1;
	localparam logic [7:0]  END_TICKS   = 8'd5;

	localparam logic [7:0]  MAX_TRACKS_RST = 8'd10;
	localparam logic [7:0]  GAP_TICKS_RST  = 8'd100;

	// Config register indexes
	localparam logic CFG_MAX_TRACKS = 1'b0;
	localparam logic CFG_GAP_TICKS  = 1'b1;

	// Queue between front and back
	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [2:0]  cmd;
		logic [13:0] value;
	} item_t;

	typedef struct packed {
		logic        line_level;
		logic        busy_res;
		logic [1:0]  play_state;
		logic [13:0] current_track;
		logic        dropped;
	} result_t;

	typedef struct packed {
		logic        is_cmd;
		cmd_t        cmd;
		logic [13:0] value;
	} q_item_t;

	typedef struct packed {
		logic [7:0] max_tracks;
		logic [7:0] gap_ticks;
	} cfg_t;

	// Decimal digits of the pending value, index 3 is thousands
	typedef logic [3:0][3:0] digits_t;

	function automatic logic [3:0] seq_length(cmd_t kind);
		logic [3:0] n;
		unique case (kind)
			OP_PLAY_TRACK: n = 4'd7;
			OP_VOLUME:     n = 4'd4;
			OP_LOOP:       n = 4'd3;
			default:       n = 4'd1;
		endcase
		return n;
	endfunction

	function automatic logic [7:0] seq_byte(cmd_t kind, logic [2:0] pos, logic [7:0] low,
			digits_t dig);
		logic [7:0] b;
		unique case (kind)
			OP_PLAY_TRACK: begin
				unique case (pos)
					3'd0:    b = CODE_STOP;
					3'd1:    b = CODE_CLEAR;
					3'd2:    b = {4'd0, dig[3]};
					3'd3:    b = {4'd0, dig[2]};
					3'd4:    b = {4'd0, dig[1]};
					3'd5:    b = {4'd0, dig[0]};
					default: b = CODE_PLAY_SPEC;
				endcase
			end
			OP_STOP: b = CODE_STOP;
			OP_VOLUME: begin
				unique case (pos)
					3'd0:    b = CODE_CLEAR;
					3'd1:    b = {4'd0, dig[1]};
					3'd2:    b = {4'd0, dig[0]};
					default: b = CODE_VOLUME;
				endcase
			end
			OP_LOOP: begin
				unique case (pos)
					3'd0:    b = CODE_CLEAR;
					3'd1:    b = low;
					default: b = CODE_LOOP;
				endcase
			end
			OP_PLAY:           b = CODE_PLAY;
			OP_PAUSE:          b = CODE_PAUSE;
			OP_TICK, OP_NEXT:  b = CODE_NEXT;
		endcase
		return b;
	endfunction

endpackage
`default_nettype wire

[rtl/owacs_front.sv]
// Front end: accept items and classify them for the queue.
`default_nettype none
module owacs_front import owacs_pkg::*; (
	input  wire logic    push,
	input  wire item_t   item,
	input  wire logic    q_full,
	output logic         q_wr,
	output q_item_t      q_data
);

	cmd_t cmd;

	assign cmd = cmd_t'(item.cmd);

	always_comb begin
		q_wr          = push && !q_full;
		q_data.is_cmd = (cmd != OP_TICK);
		q_data.cmd    = cmd;
		// clamp volume here so the back end sees the final value
		if (cmd == OP_VOLUME && item.value > VOLUME_MAX) begin
			q_data.value = VOLUME_MAX;
		end else begin
			q_data.value = item.value;
		end
	end

endmodule
`default_nettype wire

[rtl/owacs_queue.sv]
// Short queue between the front and back ends.
`default_nettype none
module owacs_queue import owacs_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    wr_en,
	input  wire q_item_t wr_data,
	output logic         q_full,
	input  wire logic    rd_en,
	output q_item_t      rd_data,
	output logic         q_empty
);

	q_item_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0]    wr_ptr_q;
	logic [QPTR_W-1:0]    rd_ptr_q;
	logic [QCNT_W-1:0]    count_q;

	assign q_full  = (count_q == QCNT_W'(QDEPTH));
	assign q_empty = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

[rtl/owacs_back.sv]
// Back end: byte sequencer, line timing, player state and result register.
`default_nettype none
module owacs_back import owacs_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire cfg_t    cfg,
	input  wire q_item_t q_data,
	input  wire logic    q_empty,
	output logic         q_rd,
	output result_t      result,
	output logic         empty,
	input  wire logic    pop
);

	phase_t      phase_q, n_phase;
	cmd_t        kind_q, n_kind;
	play_t       pst_q, n_pst;
	logic [13:0] pend_q, n_pend;
	logic [13:0] track_q, n_track;
	logic [13:0] track_inc;
	logic [2:0]  pos_q, n_pos;
	logic [7:0]  shift_q, n_shift;
	logic [3:0]  bitc_q, n_bitc;
	logic [7:0]  tick_q, n_tick;
	logic [7:0]  limit;
	logic        busy, level, drop, take;
	logic        out_valid_q;
	result_t     out_q;

	// Digit pipeline: exact reciprocal multiplies, then remainders
	logic [29:0] prod10;
	logic [28:0] prod100, prod1000;
	logic [13:0] v_s1;
	logic [10:0] q10_s1;
	logic [7:0]  q100_s1;
	logic [4:0]  q1000_s1;
	logic [13:0] rem0;
	logic [10:0] rem1;
	logic [7:0]  rem2;
	logic [4:0]  rem3;
	digits_t     dig_s2;

	assign prod10   = 30'(pend_q) * 30'd52429;
	assign prod100  = 29'(pend_q) * 29'd20972;
	assign prod1000 = 29'(pend_q) * 29'd16778;

	always_ff @(posedge clk) begin
		v_s1     <= pend_q;
		q10_s1   <= prod10[29:19];
		q100_s1  <= prod100[28:21];
		q1000_s1 <= prod1000[28:24];
	end

	always_comb begin
		rem0 = v_s1 - 14'(q10_s1) * 14'd10;
		rem1 = q10_s1 - 11'(q100_s1) * 11'd10;
		rem2 = q100_s1 - 8'(q1000_s1) * 8'd10;
		rem3 = (q1000_s1 >= 5'd10) ? q1000_s1 - 5'd10 : q1000_s1;
	end

	always_ff @(posedge clk) begin
		dig_s2[0] <= rem0[3:0];
		dig_s2[1] <= rem1[3:0];
		dig_s2[2] <= rem2[3:0];
		dig_s2[3] <= rem3[3:0];
	end

	// Take a queued item whenever the result register frees up
	assign take  = !q_empty && (!out_valid_q || pop);
	assign q_rd  = take;
	assign empty = !out_valid_q;
	assign result = out_q;

	assign track_inc = track_q + 14'd1;

	always_comb begin
		n_kind  = kind_q;
		n_pend  = pend_q;
		n_pos   = pos_q;
		n_shift = shift_q;
		n_bitc  = bitc_q;
		n_phase = phase_q;
		n_tick  = tick_q;
		n_pst   = pst_q;
		n_track = track_q;
		drop    = 1'b0;
		level   = 1'b1;
		limit   = START_TICKS;

		if (q_data.is_cmd) begin
			if (kind_q != OP_TICK) begin
				drop = 1'b1;
			end else begin
				n_kind  = q_data.cmd;
				n_pend  = q_data.value;
				if (q_data.cmd == OP_PLAY_TRACK) begin
					n_track = q_data.value;
				end
				n_pos   = 3'd0;
				n_shift = seq_byte(q_data.cmd, 3'd0, q_data.value[7:0], dig_s2);
				n_bitc  = 4'd0;
				n_phase = PH_START;
				n_tick  = 8'd0;
			end
		end

		busy = (n_kind != OP_TICK);
		if (busy) begin
			if (n_phase == PH_IDLE) begin
				n_phase = PH_START;
			end
			level  = !(n_phase == PH_LEAD || n_phase == PH_SPACE);
			n_tick = n_tick + 8'd1;
			unique case (n_phase)
				PH_LEAD:  limit = LEAD_TICKS;
				PH_MARK:  limit = n_shift[0] ? LONG_TICKS : SHORT_TICKS;
				PH_SPACE: limit = n_shift[0] ? SHORT_TICKS : LONG_TICKS;
				PH_END:   limit = END_TICKS;
				PH_GAP:   limit = (cfg.gap_ticks == 8'd0) ? 8'd1 : cfg.gap_ticks;
				default:  limit = START_TICKS;
			endcase
			if (n_tick >= limit) begin
				n_tick = 8'd0;
				unique case (n_phase)
					PH_LEAD:  n_phase = PH_MARK;
					PH_MARK:  n_phase = PH_SPACE;
					PH_SPACE: begin
						n_shift = n_shift >> 1;
						n_bitc  = n_bitc + 4'd1;
						n_phase = (n_bitc >= 4'd8) ? PH_END : PH_MARK;
					end
					PH_END: begin
						if ({1'b0, n_pos} + 4'd1 < seq_length(n_kind)) begin
							n_phase = PH_GAP;
						end else begin
							// last byte done: apply the command
							unique case (n_kind)
								OP_PLAY_TRACK, OP_PLAY: n_pst = PS_PLAYING;
								OP_STOP:                n_pst = PS_IDLE;
								OP_PAUSE:               n_pst = PS_PAUSED;
								OP_NEXT: begin
									n_pst   = PS_PLAYING;
									n_track = (track_inc > {6'd0, cfg.max_tracks}) ?
										14'd1 : track_inc;
								end
								default:                n_pst = pst_q;
							endcase
							n_kind  = OP_TICK;
							n_pos   = 3'd0;
							n_bitc  = 4'd0;
							n_phase = PH_IDLE;
						end
					end
					PH_GAP: begin
						n_pos   = n_pos + 3'd1;
						n_shift = seq_byte(n_kind, n_pos, n_pend[7:0], dig_s2);
						n_bitc  = 4'd0;
						n_phase = PH_START;
					end
					default:  n_phase = PH_LEAD;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else if (take) begin
			phase_q <= n_phase;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q      <= OP_TICK;
			pst_q       <= PS_IDLE;
			pend_q      <= 14'd0;
			track_q     <= 14'd1;
			pos_q       <= 3'd0;
			shift_q     <= 8'd0;
			bitc_q      <= 4'd0;
			tick_q      <= 8'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				kind_q  <= n_kind;
				pst_q   <= n_pst;
				pend_q  <= n_pend;
				track_q <= n_track;
				pos_q   <= n_pos;
				shift_q <= n_shift;
				bitc_q  <= n_bitc;
				tick_q  <= n_tick;
			end
			if (take) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q.line_level    <= level;
			out_q.busy_res      <= busy;
			out_q.play_state    <= busy ? PS_SENDING : n_pst;
			out_q.current_track <= n_track;
			out_q.dropped       <= drop;
		end
	end

endmodule
`default_nettype wire

[rtl/one_wire_audio_command_sender.sv]
// Top level of the one-wire audio command sender.
//
// Input channel: one item per 200 us tick, a plain tick (cmd 0) or a command
// with its value. Push it while full is low; it transfers at that edge.
// Result channel: exactly one result per item, in order. While empty is low
// the oldest result sits on the result port; it transfers at an edge with pop.
// Configuration: write max_tracks (index 0) or gap_ticks (index 1) through
// cfg_we/cfg_index/cfg_data while no item is in flight.
// Throughput: one item per cycle, sustained, as long as results are popped.
// Path: an item that enters the empty block is registered in the queue, then
// crosses it and lands in the result register at the next edge.
// Each tick is one step of the back end sequencer, which sets the
// rate; decimal digits of a track or volume are worked out in a two-stage
// pipeline beside it, long before the first digit byte is due.
// Stall: while pop stays low the result register holds and the queue fills;
// full rises once four items wait, and nothing is lost.
// Reset: asynchronous, active low. The player is idle on track 1, the line is
// high, the queue and result register are empty, max_tracks is 10 and
// gap_ticks is 100.
`default_nettype none
module one_wire_audio_command_sender import owacs_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire item_t      item,
	output logic            empty,
	input  wire logic       pop,
	output result_t         result,
	input  wire logic       cfg_we,
	input  wire logic       cfg_index,
	input  wire logic [7:0] cfg_data
);

	cfg_t    cfg_q;
	logic    q_wr, q_rd, q_empty;
	q_item_t q_in, q_out;

	// Hold the configuration registers; writes land at once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_tracks <= MAX_TRACKS_RST;
			cfg_q.gap_ticks  <= GAP_TICKS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MAX_TRACKS: cfg_q.max_tracks <= cfg_data;
				CFG_GAP_TICKS:  cfg_q.gap_ticks  <= cfg_data;
			endcase
		end
	end

	// Classify and clamp each accepted item.
	owacs_front u_front (
		.push   (push),
		.item   (item),
		.q_full (full),
		.q_wr   (q_wr),
		.q_data (q_in)
	);

	// Decouple the input side from back end stalls.
	owacs_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_wr),
		.wr_data (q_in),
		.q_full  (full),
		.rd_en   (q_rd),
		.rd_data (q_out),
		.q_empty (q_empty)
	);

	// Advance the byte sequencer one tick per item and register the result.
	owacs_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_data  (q_out),
		.q_empty (q_empty),
		.q_rd    (q_rd),
		.result  (result),
		.empty   (empty),
		.pop     (pop)
	);

endmodule
`default_nettype wire

[rtl/owacs_checker.sv]
// Port-level checks of the command sender and their bind.
`default_nettype none
`include "one_wire_audio_command_sender_defines.svh"
module owacs_checker import owacs_pkg::*; (
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    full,
	input wire logic    empty,
	input wire logic    pop,
	input wire result_t result
);

	// a waiting result holds until it transfers
	`OWACS_ASSERT_NEXT(a_hold_result, clk, arst_n, !empty && !pop, !empty && $stable(result))
	// a full queue with a free result register must drain into it
	`OWACS_ASSERT_NEXT(a_drain_full, clk, arst_n, empty && full, !empty)
	// the queue can only fill up while the result side stalls
	`OWACS_ASSERT_SAME(a_full_on_stall, clk, arst_n, $rose(full), $past(!empty && !pop))

endmodule

bind one_wire_audio_command_sender owacs_checker u_owacs_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.full   (full),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);
`default_nettype wire

[bench/one_wire_audio_command_sender_test.sv]
// Self-checking bench for the one-wire audio command sender: per-tick prediction, random traffic.
`timescale 1ns / 100ps
module one_wire_audio_command_sender_test;
	import owacs_pkg::*;

	localparam int LIMIT_CYCLES = 1_000_000;
	// One byte on the line: start 5, lead 20, eight bits of 4 ticks each, end 5
	localparam int BYTE_TICKS = 62;

	logic clk;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	item_t cmd_word = '0;
	logic empty;
	logic pop = 1'b0;
	result_t res_word;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [7:0] cfg_data = 8'd0;

	one_wire_audio_command_sender dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(cmd_word),
		.empty(empty),
		.pop(pop),
		.result(res_word),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Player model: one call per accepted tick, blocking updates only.
	// ------------------------------------------------------------------
	play_t       pl_state;
	logic [13:0] track;
	logic [13:0] pend_val;
	cmd_t        seq_kind;   // OP_TICK means no sequence on the line
	logic [2:0]  byte_pos;
	logic [7:0]  shreg;
	logic [3:0]  bit_cnt;
	phase_t      phase;
	logic [7:0]  tick_cnt;
	logic [7:0]  max_tracks_cfg;
	logic [7:0]  gap_cfg;

	result_t     expected_ticks[$];
	item_t       pending_items[$];
	int          seq_left;   // ticks the sequence on the line still needs, as seen by the generator
	int          errors = 0;
	int          results_seen = 0;
	int          cycle_count = 0;

	task automatic reset_player();
		pl_state = PS_IDLE;
		track = 14'd1;
		pend_val = 14'd0;
		seq_kind = OP_TICK;
		byte_pos = 3'd0;
		shreg = 8'd0;
		bit_cnt = 4'd0;
		phase = PH_IDLE;
		tick_cnt = 8'd0;
		max_tracks_cfg = MAX_TRACKS_RST;
		gap_cfg = GAP_TICKS_RST;
	endtask

	function automatic int byte_count(cmd_t kind);
		case (kind)
			OP_PLAY_TRACK: return 7;
			OP_VOLUME:     return 4;
			OP_LOOP:       return 3;
			default:       return 1;
		endcase
	endfunction

	function automatic logic [7:0] command_byte(cmd_t kind, logic [2:0] pos, logic [13:0] v);
		int n;
		n = int'(v);
		case (kind)
			OP_PLAY_TRACK: begin
				case (pos)
					3'd0:    return CODE_STOP;
					3'd1:    return CODE_CLEAR;
					// digits go out thousands first, each taken modulo 10
					3'd2:    return 8'((n / 1000) % 10);
					3'd3:    return 8'((n / 100) % 10);
					3'd4:    return 8'((n / 10) % 10);
					3'd5:    return 8'(n % 10);
					default: return CODE_PLAY_SPEC;
				endcase
			end
			OP_STOP: return CODE_STOP;
			OP_VOLUME: begin
				case (pos)
					3'd0:    return CODE_CLEAR;
					3'd1:    return 8'(n / 10);
					3'd2:    return 8'(n % 10);
					default: return CODE_VOLUME;
				endcase
			end
			OP_LOOP: begin
				case (pos)
					3'd0:    return CODE_CLEAR;
					3'd1:    return v[7:0];
					default: return CODE_LOOP;
				endcase
			end
			OP_PLAY:  return CODE_PLAY;
			OP_PAUSE: return CODE_PAUSE;
			default:  return CODE_NEXT;
		endcase
	endfunction

	// Length of the current line phase; a one bit is long high, short low
	function automatic logic [7:0] phase_length();
		case (phase)
			PH_LEAD:  return LEAD_TICKS;
			PH_MARK:  return shreg[0] ? LONG_TICKS : SHORT_TICKS;
			PH_SPACE: return shreg[0] ? SHORT_TICKS : LONG_TICKS;
			PH_END:   return END_TICKS;
			PH_GAP:   return (gap_cfg == 8'd0) ? 8'd1 : gap_cfg;
			default:  return START_TICKS;
		endcase
	endfunction

	task automatic load_next_byte();
		shreg = command_byte(seq_kind, byte_pos, pend_val);
		bit_cnt = 4'd0;
		phase = PH_START;
		tick_cnt = 8'd0;
	endtask

	// Apply the command's effect on the last tick of its sequence and free the line
	task automatic end_sequence();
		case (seq_kind)
			OP_PLAY_TRACK, OP_PLAY: pl_state = PS_PLAYING;
			OP_STOP:                pl_state = PS_IDLE;
			OP_PAUSE:               pl_state = PS_PAUSED;
			OP_NEXT: begin
				track = track + 14'd1;
				if (track > {6'd0, max_tracks_cfg})
					track = 14'd1;
				pl_state = PS_PLAYING;
			end
			default: ;
		endcase
		seq_kind = OP_TICK;
		byte_pos = 3'd0;
		bit_cnt = 4'd0;
		phase = PH_IDLE;
		tick_cnt = 8'd0;
	endtask

	task automatic step_player(input item_t it, output result_t r);
		logic lvl;
		logic busy;
		logic drop;
		lvl = 1'b1;
		drop = 1'b0;
		if (cmd_t'(it.cmd) != OP_TICK) begin
			// a command while a sequence runs, its last tick included, is lost
			if (seq_kind != OP_TICK) begin
				drop = 1'b1;
			end else begin
				seq_kind = cmd_t'(it.cmd);
				if (seq_kind == OP_VOLUME && it.value > VOLUME_MAX)
					pend_val = VOLUME_MAX;
				else
					pend_val = it.value;
				if (seq_kind == OP_PLAY_TRACK)
					track = it.value;
				byte_pos = 3'd0;
				load_next_byte();
			end
		end
		busy = (seq_kind != OP_TICK);
		if (busy) begin
			lvl = (phase == PH_LEAD || phase == PH_SPACE) ? 1'b0 : 1'b1;
			tick_cnt = tick_cnt + 8'd1;
			if (tick_cnt >= phase_length()) begin
				tick_cnt = 8'd0;
				case (phase)
					PH_START: phase = PH_LEAD;
					PH_LEAD:  phase = PH_MARK;
					PH_MARK:  phase = PH_SPACE;
					PH_SPACE: begin
						shreg = shreg >> 1;
						bit_cnt = bit_cnt + 4'd1;
						if (bit_cnt >= 4'd8)
							phase = PH_END;
						else
							phase = PH_MARK;
					end
					PH_END: begin
						if (int'(byte_pos) + 1 < byte_count(seq_kind))
							phase = PH_GAP;
						else
							end_sequence();
					end
					default: begin
						byte_pos = byte_pos + 3'd1;
						load_next_byte();
					end
				endcase
			end
		end
		r.line_level = lvl;
		r.busy_res = busy;
		r.play_state = busy ? PS_SENDING : pl_state;
		r.current_track = track;
		r.dropped = drop;
	endtask

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------
	task automatic flag(string msg);
		errors++;
		$display("MISMATCH %s", msg);
	endtask

	task automatic compare_field(string name, logic [13:0] got, logic [13:0] want);
		if (got !== want)
			flag($sformatf("result %0d %s: got %0d, expected %0d", results_seen, name, got, want));
	endtask

	result_t predicted;
	result_t oldest;
	logic    took_item = 1'b0;
	logic    took_result = 1'b0;

	// Sample both handshakes at the rising edge; predict on every input transfer
	// and compare every result transfer against the oldest prediction.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		took_item <= arst_n && push && !full;
		took_result <= arst_n && pop && !empty;
		if (arst_n && push && !full) begin
			step_player(cmd_word, predicted);
			expected_ticks.push_back(predicted);
		end
		if (arst_n && pop && !empty) begin
			if (expected_ticks.size() == 0) begin
				flag($sformatf("result %0d arrived with no tick waiting", results_seen));
			end else begin
				oldest = expected_ticks.pop_front();
				compare_field("line_level", 14'(res_word.line_level), 14'(oldest.line_level));
				compare_field("busy_res", 14'(res_word.busy_res), 14'(oldest.busy_res));
				compare_field("play_state", 14'(res_word.play_state), 14'(oldest.play_state));
				compare_field("current_track", res_word.current_track, oldest.current_track);
				compare_field("dropped", 14'(res_word.dropped), 14'(oldest.dropped));
			end
			results_seen++;
		end
	end

	// ------------------------------------------------------------------
	// Sender and receiver, both moving at the falling edge
	// ------------------------------------------------------------------
	int   in_wait = 0;
	int   out_wait = 0;
	logic in_lazy = 1'b1;
	logic out_lazy = 1'b0;

	// Feed items from the pending queue; after each transfer draw a random wait
	// while in lazy mode, none otherwise. Flip the mode now and then so
	// that long back-to-back stretches occur too.
	always @(negedge clk) begin : feed
		int w;
		if (!arst_n) begin
			push <= 1'b0;
			in_wait <= 0;
		end else if (push && !took_item) begin
			// hold the item until it transfers
		end else if (push) begin
			if ($urandom_range(0, 39) == 0)
				in_lazy <= ~in_lazy;
			w = in_lazy ? int'($urandom_range(0, 19)) : 0;
			if (w == 0 && pending_items.size() != 0) begin
				cmd_word <= pending_items.pop_front();
			end else begin
				push <= 1'b0;
				in_wait <= (w == 0) ? 0 : w - 1;
			end
		end else if (in_wait != 0) begin
			in_wait <= in_wait - 1;
		end else if (pending_items.size() != 0) begin
			cmd_word <= pending_items.pop_front();
			push <= 1'b1;
		end
	end

	// Take results; after each transfer, in lazy mode, stall pop for a random wait
	always @(negedge clk) begin : drain
		int w;
		if (!arst_n) begin
			pop <= 1'b0;
			out_wait <= 0;
		end else if (pop && took_result) begin
			if ($urandom_range(0, 39) == 0)
				out_lazy <= ~out_lazy;
			w = out_lazy ? int'($urandom_range(0, 19)) : 0;
			if (w != 0) begin
				pop <= 1'b0;
				out_wait <= w - 1;
			end
		end else if (!pop) begin
			if (out_wait != 0)
				out_wait <= out_wait - 1;
			else
				pop <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus generation
	// ------------------------------------------------------------------
	// Ticks a command occupies on the line under the current gap setting
	function automatic int seq_span(cmd_t kind);
		int g;
		g = (gap_cfg == 8'd0) ? 1 : int'(gap_cfg);
		return byte_count(kind) * BYTE_TICKS + (byte_count(kind) - 1) * g;
	endfunction

	task automatic send_item(cmd_t c, logic [13:0] v);
		item_t it;
		it.cmd = c;
		it.value = v;
		pending_items.push_back(it);
		if (c != OP_TICK && seq_left == 0)
			seq_left = seq_span(c);
		if (seq_left > 0)
			seq_left--;
	endtask

	// Pad with plain ticks, random value bits as noise, until the line is free
	task automatic settle();
		while (seq_left > 0)
			send_item(OP_TICK, 14'($urandom));
	endtask

	task automatic issue(cmd_t c, logic [13:0] v);
		send_item(c, v);
		settle();
	endtask

	function automatic logic [13:0] pick_value(cmd_t c);
		case (c)
			OP_PLAY_TRACK: begin
				if ($urandom_range(0, 3) == 0)
					return 14'($urandom_range(10000, 16383));
				return 14'($urandom_range(0, 9999));
			end
			OP_VOLUME: begin
				if ($urandom_range(0, 3) == 0)
					return 14'($urandom);
				return 14'($urandom_range(0, 40));
			end
			default: return 14'($urandom);
		endcase
	endfunction

	// Mostly start a command as soon as the line is free; sometimes collide with
	// a running sequence, often right on its last tick.
	task automatic random_phase(int n);
		int k;
		cmd_t c;
		for (k = 0; k < n; k++) begin
			c = cmd_t'($urandom_range(1, 7));
			if (seq_left == 0 && $urandom_range(0, 9) < 7)
				send_item(c, pick_value(c));
			else if (seq_left == 1 && $urandom_range(0, 1) == 1)
				send_item(c, pick_value(c));
			else if (seq_left > 1 && $urandom_range(0, 49) == 0)
				send_item(c, pick_value(c));
			else
				send_item(OP_TICK, 14'($urandom));
		end
		settle();
	endtask

	// Wait until every queued item has transferred and every result has come back
	task automatic wait_drained();
		@(negedge clk);
		while (pending_items.size() != 0 || push || expected_ticks.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(logic idx, logic [7:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_MAX_TRACKS)
			max_tracks_cfg = data;
		else
			gap_cfg = data;
	endtask

	// Abort a hung run
	initial begin
		wait (cycle_count >= LIMIT_CYCLES);
		$display("one_wire_audio_command_sender_test NOT OK");
		$finish;
	end

	initial begin
		reset_player();
		seq_left = 0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// Single-byte commands at the reset settings
		issue(OP_PLAY, 14'd0);
		issue(OP_PAUSE, 14'd0);
		issue(OP_STOP, 14'd0);
		// Loop mode with every value bit set; collide once mid-byte, once on the last tick
		send_item(OP_LOOP, 14'h3FFF);
		send_item(OP_PLAY, 14'd0);
		while (seq_left > 1)
			send_item(OP_TICK, 14'd0);
		send_item(OP_NEXT, 14'd0);
		wait_drained();

		// Zero gap acts as one tick
		write_reg(CFG_GAP_TICKS, 8'd0);
		// Track past 9999 keeps its value; next then wraps the 14-bit count to 0
		issue(OP_PLAY_TRACK, 14'd16383);
		issue(OP_NEXT, 14'd0);
		issue(OP_NEXT, 14'd0);
		// Start right on the tick after the line frees up; volume above the clamp
		issue(OP_VOLUME, 14'd45);
		wait_drained();

		// Zero max_tracks: next lands on track 1 unless the 14-bit count wraps to 0
		write_reg(CFG_MAX_TRACKS, 8'd0);
		write_reg(CFG_GAP_TICKS, 8'd1);
		random_phase(40);
		wait_drained();

		// Let any stray result show up before the verdict
		repeat (8) @(negedge clk);
		if (errors == 0)
			$display("one_wire_audio_command_sender_test OK");
		else
			$display("one_wire_audio_command_sender_test NOT OK");
		$finish;
	end

endmodule

[one_wire_audio_command_sender.f]
+incdir+rtl
rtl/owacs_pkg.sv
rtl/owacs_front.sv
rtl/owacs_queue.sv
rtl/owacs_back.sv
rtl/one_wire_audio_command_sender.sv
rtl/owacs_checker.sv
bench/one_wire_audio_command_sender_test.sv
